// ===== src/wdnr_pkg.sv =====
package wdnr_pkg;

  localparam int WIDE_BITS = 192;
  localparam int MAX_SCALE = 28;
  localparam int VAL_W     = 192;
  localparam int REM_W     = 30;
  localparam int SCL_W     = 9;
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = VAL_W / DIV_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_WAIT,
    S_POST,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    P_WIDE,
    P_ROUND,
    P_TRIM,
    P_ST_WIDE,
    P_ST_OVF,
    P_ST_SCALE
  } phase_t;

  typedef enum logic [1:0] {
    D_TEN,
    D_E8,
    D_E9
  } dsel_t;

  typedef enum logic [1:0] {
    ST_FITS    = 2'd0,
    ST_BIG_POS = 2'd1,
    ST_BAD     = 2'd2
  } status_t;

  typedef struct packed {
    logic  start;
    dsel_t dsel;
  } div_cmd_t;

  function automatic logic [REM_W-1:0] divisor(input dsel_t sel);
    logic [REM_W-1:0] d;
    case (sel)
      D_TEN:   d = REM_W'(10);
      D_E8:    d = REM_W'(100000000);
      D_E9:    d = REM_W'(1000000000);
      default: d = REM_W'(10);
    endcase
    return d;
  endfunction

endpackage

// ===== src/wdnr_div.sv =====
module wdnr_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wdnr_pkg::div_cmd_t            cmd,
  input  logic [wdnr_pkg::VAL_W-1:0]    dividend,
  output logic [wdnr_pkg::VAL_W-1:0]    quot,
  output logic [wdnr_pkg::REM_W-1:0]    rem,
  output logic                          done
);

  localparam int CNT_W = $clog2(wdnr_pkg::DIV_STEPS);
  localparam int VW    = wdnr_pkg::VAL_W;
  localparam int RW    = wdnr_pkg::REM_W;
  localparam int DB    = wdnr_pkg::DIV_BITS;

  logic [VW-1:0]    work_r, work_nxt;
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [RW-1:0]    dvsr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [RW-1:0]    r;
  logic [RW:0]      cur;
  logic [DB-1:0]    qb;

  always_comb begin
    r = rem_r;
    qb = '0;
    cur = '0;
    for (int i = 0; i < DB; i++) begin
      cur = {r, work_r[VW-1-i]};
      if (cur >= {1'b0, dvsr_r}) begin
        cur = cur - {1'b0, dvsr_r};
        qb[DB-1-i] = 1'b1;
      end
      r = cur[RW-1:0];
    end
  end

  always_comb begin
    work_nxt = work_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      work_nxt = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      work_nxt = {work_r[VW-DB-1:0], qb};
      rem_nxt  = r;
      cnt_nxt  = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(wdnr_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    if (cmd.start) begin
      dvsr_r <= wdnr_pkg::divisor(cmd.dsel);
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign quot = work_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

// ===== src/wide_decimal_narrow_round.sv =====
// each pass is one 192-bit divide by 10, 1e8 or 1e9 in the shared divider: 24 steps of
// 8 quotient bits, issued from the decide state and taken in the post state
// one transaction at a time, a new one taken only back in idle; the number of passes is
// set by the data and the scale, all through that single divider
// reset: synchronous active-low rst_n clears the sequencer and the output valid
module wide_decimal_narrow_round (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [199:0] in_tdata,   // mag_low, mag_mid, mag_high, scale_in, sign_in
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // mant_low, mant_high, scale_out, sign_out, status
);

  localparam int VW = wdnr_pkg::VAL_W;
  localparam int RW = wdnr_pkg::REM_W;
  localparam int SW = wdnr_pkg::SCL_W;
  localparam logic signed [SW-1:0] MAXS = SW'(wdnr_pkg::MAX_SCALE);

  wdnr_pkg::state_t  state_r, state_nxt;
  wdnr_pkg::phase_t  phase_r, phase_nxt;
  wdnr_pkg::div_cmd_t cmd;

  logic [VW-1:0]        val_r, val_nxt;
  logic [VW-1:0]        orig_r, orig_nxt;
  logic signed [SW-1:0] scale_r, scale_nxt;
  logic [6:0]           oscale_r, oscale_nxt;
  logic                 sign_r, sign_nxt;
  logic [1:0]           st_r, st_nxt;
  logic [95:0]          mant_r, mant_nxt;
  logic [4:0]           rscale_r, rscale_nxt;

  logic                 out_valid_r;
  logic [103:0]         out_data_r;

  logic [VW-1:0]        quot;
  logic [RW-1:0]        rem;
  logic                 div_done;

  logic big, wide8, wide9, nz, over, pos;
  logic dec_div, dec_fin, start_status, in_acc, out_free;
  wdnr_pkg::dsel_t dsel;

  assign big   = |val_r[VW-1:96];
  assign wide8 = |val_r[VW-1:wdnr_pkg::WIDE_BITS-68];
  assign wide9 = |val_r[VW-1:wdnr_pkg::WIDE_BITS-67];
  assign nz    = |val_r;
  assign over  = scale_r > MAXS;
  assign pos   = scale_r > SW'(0);

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  wdnr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .dividend (val_r),
    .quot     (quot),
    .rem      (rem),
    .done     (div_done)
  );

  always_comb begin
    val_nxt      = val_r;
    orig_nxt     = orig_r;
    scale_nxt    = scale_r;
    oscale_nxt   = oscale_r;
    sign_nxt     = sign_r;
    st_nxt       = st_r;
    phase_nxt    = phase_r;
    mant_nxt     = mant_r;
    rscale_nxt   = rscale_r;
    dec_div      = 1'b0;
    dec_fin      = 1'b0;
    dsel         = wdnr_pkg::D_TEN;
    start_status = 1'b0;
    case (state_r)
      wdnr_pkg::S_IDLE: begin
        if (in_acc) begin
          val_nxt    = in_tdata[191:0];
          orig_nxt   = in_tdata[191:0];
          oscale_nxt = in_tdata[198:192];
          scale_nxt  = SW'(in_tdata[198:192]);
          sign_nxt   = in_tdata[199];
          st_nxt     = wdnr_pkg::ST_FITS;
          phase_nxt  = wdnr_pkg::P_WIDE;
        end
      end
      wdnr_pkg::S_DECIDE: begin
        case (phase_r)
          wdnr_pkg::P_WIDE: begin
            if (wide8) begin
              dec_div = 1'b1;
              dsel    = wdnr_pkg::D_E8;
            end else begin
              phase_nxt = wdnr_pkg::P_ROUND;
            end
          end
          wdnr_pkg::P_ROUND: begin
            if (big || over) dec_div = 1'b1;
            else phase_nxt = wdnr_pkg::P_TRIM;
          end
          wdnr_pkg::P_TRIM: begin
            if (pos) dec_div = 1'b1;
            else start_status = 1'b1;
          end
          wdnr_pkg::P_ST_WIDE: begin
            if (wide9) begin
              dec_div = 1'b1;
              dsel    = wdnr_pkg::D_E9;
            end else if (big) begin
              phase_nxt = wdnr_pkg::P_ST_OVF;
            end else begin
              phase_nxt = wdnr_pkg::P_ST_SCALE;
            end
          end
          wdnr_pkg::P_ST_OVF: begin
            if (big && pos) begin
              dec_div = 1'b1;
            end else begin
              if (big) st_nxt = sign_r ? wdnr_pkg::ST_BAD : wdnr_pkg::ST_BIG_POS;
              phase_nxt = wdnr_pkg::P_ST_SCALE;
            end
          end
          wdnr_pkg::P_ST_SCALE: begin
            if (over && nz) begin
              dec_div = 1'b1;
            end else begin
              if (over) st_nxt = wdnr_pkg::ST_BAD;
              dec_fin = 1'b1;
            end
          end
          default: dec_fin = 1'b1;
        endcase
      end
      wdnr_pkg::S_POST: begin
        case (phase_r)
          wdnr_pkg::P_WIDE: begin
            val_nxt   = quot;
            scale_nxt = scale_r - SW'(8);
          end
          wdnr_pkg::P_ST_WIDE: begin
            val_nxt   = quot;
            scale_nxt = scale_r - SW'(9);
          end
          wdnr_pkg::P_ROUND: begin
            val_nxt   = quot + VW'(rem > RW'(5) || (rem == RW'(5) && quot[0]));
            scale_nxt = scale_r - SW'(1);
          end
          wdnr_pkg::P_TRIM: begin
            if (rem == '0) begin
              val_nxt   = quot;
              scale_nxt = scale_r - SW'(1);
            end else begin
              start_status = 1'b1;
            end
          end
          default: begin
            val_nxt   = quot;
            scale_nxt = scale_r - SW'(1);
          end
        endcase
      end
      default: ;
    endcase
    if (start_status) begin
      mant_nxt   = val_r[95:0];
      rscale_nxt = scale_r[SW-1] ? 5'd0 : scale_r[4:0];
      val_nxt    = orig_r;
      scale_nxt  = SW'(oscale_r);
      phase_nxt  = wdnr_pkg::P_ST_WIDE;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wdnr_pkg::S_IDLE:   if (in_acc) state_nxt = wdnr_pkg::S_DECIDE;
      wdnr_pkg::S_DECIDE: begin
        if (dec_div) state_nxt = wdnr_pkg::S_WAIT;
        else if (dec_fin) state_nxt = wdnr_pkg::S_OUT;
      end
      wdnr_pkg::S_WAIT:   if (div_done) state_nxt = wdnr_pkg::S_POST;
      wdnr_pkg::S_POST:   state_nxt = wdnr_pkg::S_DECIDE;
      wdnr_pkg::S_OUT:    if (out_free) state_nxt = wdnr_pkg::S_IDLE;
      default:            state_nxt = wdnr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == wdnr_pkg::S_IDLE);
    cmd.start = (state_r == wdnr_pkg::S_DECIDE) && dec_div;
    cmd.dsel  = dsel;
  end

  always_ff @(posedge clk) begin
    val_r    <= val_nxt;
    orig_r   <= orig_nxt;
    scale_r  <= scale_nxt;
    oscale_r <= oscale_nxt;
    sign_r   <= sign_nxt;
    st_r     <= st_nxt;
    mant_r   <= mant_nxt;
    rscale_r <= rscale_nxt;
    if (state_r == wdnr_pkg::S_OUT && out_free) begin
      out_data_r <= {st_r, sign_r, rscale_r, mant_r};
    end
    if (!rst_n) begin
      state_r     <= wdnr_pkg::S_IDLE;
      phase_r     <= wdnr_pkg::P_WIDE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (state_r == wdnr_pkg::S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== src/wdnr_checker.sv =====
module wdnr_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction taken while busy");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[103:102] != 2'd3)
    else $error("undefined status code");

  a_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[100:96] <= 5'(wdnr_pkg::MAX_SCALE))
    else $error("result scale above limit");

endmodule

bind wide_decimal_narrow_round wdnr_checker u_wdnr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
